// File: sv/srroa_pkg.sv
// Shared types and constants for the sample-rate repeat-or-average block.
// Holds the item structs, the CSR indexes and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srroa_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int FACTOR_W   = 4;
   localparam int CSR_DATA_W = 4;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACTOR    = 1'd1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       stream_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       run_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REPEAT,
      ST_ACCUM,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic accumulate;
      logic div_step;
      logic emit_avg;
      logic emit_rep;
   } cmd_type;

   typedef struct packed {
      logic slow_mode;
      logic group_done;
      logic rep_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: sv/srroa_datapath.sv
// Datapath: configuration registers, item register, group accumulator,
// one-bit-per-cycle restoring divider and the result register.
// Depends on srroa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srroa_datapath #(
   parameter int MAX_FACTOR = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [srroa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srroa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  srroa_pkg::req_type                req_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output srroa_pkg::rsp_type                rsp_data,
   input  srroa_pkg::cmd_type                cmd,
   output srroa_pkg::status_type             status
);
   import srroa_pkg::*;

   localparam int SUM_W  = SAMPLE_W + $clog2(MAX_FACTOR);
   localparam int CNT_W  = $clog2(MAX_FACTOR);
   localparam int CMP_W  = (CNT_W + 1 > FACTOR_W) ? CNT_W + 1 : FACTOR_W;
   localparam int DCNT_W = $clog2(SUM_W);

   logic                    slow_mode_ff, slow_mode_in;
   logic [FACTOR_W-1:0]     factor_ff, factor_in;
   logic signed [SUM_W-1:0] group_sum_ff, group_sum_in;
   logic [CNT_W-1:0]        group_count_ff, group_count_in;
   logic [FACTOR_W-1:0]     rep_count_ff, rep_count_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   req_type                 item_ff, item_in;
   logic                    neg_ff, neg_in;
   logic [SUM_W-1:0]        dq_ff, dq_in;
   logic [FACTOR_W-1:0]     rem_ff, rem_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [FACTOR_W-1:0]     eff_factor;
   logic signed [SUM_W-1:0] sum_new;
   logic [SUM_W-1:0]        sum_mag;
   logic [CMP_W-1:0]        count_new;
   logic                    group_done;
   logic                    rep_last;
   logic [FACTOR_W:0]       trial;
   logic                    trial_ge;
   logic [SUM_W-1:0]        avg;
   logic                    out_free;

   // Zero counts as one, anything above the limit saturates
   always_comb begin
      if (factor_ff == '0) begin
         eff_factor = FACTOR_W'(1);
      end else if (int'(factor_ff) > MAX_FACTOR) begin
         eff_factor = FACTOR_W'(MAX_FACTOR);
      end else begin
         eff_factor = factor_ff;
      end
   end

   assign sum_new    = group_sum_ff + SUM_W'($signed(item_ff.sample_in));
   assign sum_mag    = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
   assign count_new  = CMP_W'(group_count_ff) + CMP_W'(1);
   assign group_done = count_new >= CMP_W'(eff_factor);
   assign rep_last   = FACTOR_W'(rep_count_ff + FACTOR_W'(1)) == eff_factor;

   // Restoring step: remainder stays below the divisor
   assign trial    = {rem_ff, dq_ff[SUM_W-1]};
   assign trial_ge = trial >= {1'b0, eff_factor};
   assign avg      = neg_ff ? SUM_W'(-dq_ff) : dq_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      slow_mode_in   = slow_mode_ff;
      factor_in      = factor_ff;
      group_sum_in   = group_sum_ff;
      group_count_in = group_count_ff;
      rep_count_in   = rep_count_ff;
      dcnt_in        = dcnt_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_avg || cmd.emit_rep) begin
         rsp_valid_in = 1'b1;
      end

      if (cmd.load_item) begin
         rep_count_in = '0;
      end

      if (cmd.accumulate) begin
         dcnt_in = '0;
         if (group_done || item_ff.stream_end) begin
            group_sum_in   = '0;
            group_count_in = '0;
         end else begin
            group_sum_in   = sum_new;
            group_count_in = count_new[CNT_W-1:0];
         end
      end

      if (cmd.div_step) begin
         dcnt_in = DCNT_W'(dcnt_ff + DCNT_W'(1));
      end

      if (cmd.emit_rep) begin
         if (rep_last) begin
            rep_count_in = '0;
            if (item_ff.stream_end) begin
               group_sum_in   = '0;
               group_count_in = '0;
            end
         end else begin
            rep_count_in = FACTOR_W'(rep_count_ff + FACTOR_W'(1));
         end
      end

      // A register write drops any partial group
      if (csr_we) begin
         case (csr_index)
            CSR_SLOW_MODE: slow_mode_in = csr_wdata[0];
            CSR_FACTOR:    factor_in    = csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
         group_sum_in   = '0;
         group_count_in = '0;
      end
   end

   always_comb begin
      item_in     = item_ff;
      neg_in      = neg_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      rsp_data_in = rsp_data_ff;

      if (cmd.load_item) begin
         item_in = req_data;
      end

      if (cmd.accumulate && group_done) begin
         neg_in = sum_new[SUM_W-1];
         dq_in  = sum_mag;
         rem_in = '0;
      end

      if (cmd.div_step) begin
         dq_in  = {dq_ff[SUM_W-2:0], trial_ge};
         rem_in = trial_ge ? FACTOR_W'(trial - {1'b0, eff_factor})
                           : trial[FACTOR_W-1:0];
      end

      if (cmd.emit_avg) begin
         rsp_data_in.sample_out = avg[SAMPLE_W-1:0];
         rsp_data_in.run_last   = 1'b1;
      end else if (cmd.emit_rep) begin
         rsp_data_in.sample_out = item_ff.sample_in;
         rsp_data_in.run_last   = rep_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_mode_ff   <= 1'b0;
         factor_ff      <= FACTOR_W'(1);
         group_sum_ff   <= '0;
         group_count_ff <= '0;
         rep_count_ff   <= '0;
         dcnt_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         slow_mode_ff   <= slow_mode_in;
         factor_ff      <= factor_in;
         group_sum_ff   <= group_sum_in;
         group_count_ff <= group_count_in;
         rep_count_ff   <= rep_count_in;
         dcnt_ff        <= dcnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      neg_ff      <= neg_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.slow_mode  = slow_mode_ff;
   assign status.group_done = group_done;
   assign status.rep_last   = rep_last;
   assign status.div_last   = dcnt_ff == DCNT_W'(SUM_W - 1);
   assign status.out_free   = out_free;

endmodule

`default_nettype wire

// File: sv/srroa_ctrl.sv
// Controller state machine: sequences accept, repeat, accumulate, divide and
// emit, and drives the datapath commands.
// Depends on srroa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srroa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srroa_pkg::status_type status,
   output srroa_pkg::cmd_type    cmd
);
   import srroa_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.slow_mode ? ST_REPEAT : ST_ACCUM;
            end
         end
         ST_REPEAT: begin
            if (status.out_free && status.rep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ACCUM: begin
            state_in = status.group_done ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_REPEAT: cmd.emit_rep   = status.out_free;
         ST_ACCUM:  cmd.accumulate = 1'b1;
         ST_DIVIDE: cmd.div_step   = 1'b1;
         ST_EMIT:   cmd.emit_avg   = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/sample_rate_repeat_or_average.sv
// Sample-rate changer by a whole factor. With slow_mode set, each accepted
// item is sent factor times, the last copy flagged run_last; with slow_mode
// clear, each group of factor items gives one result, the group sum divided
// by factor and truncated toward zero. An item flagged stream_end drops any
// partial group, and so does any register write. A factor of zero acts as
// one and a factor above MAX_FACTOR as MAX_FACTOR. In slow mode, an item is
// taken and its copies then sent, each held while the result side stalls;
// in fast mode, an item that leaves its group open is taken and added to
// the sum, and one that completes it is taken, added, divided and emitted
// once the result side is free. The divider works on a sum of SUM_W =
// 16 + clog2(MAX_FACTOR) bits and retires one quotient bit a cycle. The
// block takes one item at a time; the result register lets the next item in while an earlier result still waits.
// Depends on srroa_pkg, srroa_ctrl and srroa_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sample_rate_repeat_or_average #(
   parameter int MAX_FACTOR = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  srroa_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output srroa_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [srroa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srroa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import srroa_pkg::*;

   cmd_type    cmd;
   status_type status;

   srroa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   srroa_datapath #(
      .MAX_FACTOR (MAX_FACTOR)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   // Busy straight after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous item still in work");

   // Never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_avg || cmd.emit_rep |-> !rsp_valid || rsp_ready)
      else $error("result register overwritten");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.accumulate, cmd.div_step, cmd.emit_avg, cmd.emit_rep}))
      else $error("more than one datapath command at once");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit_avg || cmd.emit_rep))
      else $error("result raised without an emit command");

endmodule

`default_nettype wire
